// ===== hdl/burst_fifo_with_peek_ack_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef BURST_FIFO_WITH_PEEK_ACK_UNIT_DEFINES_SVH
`define BURST_FIFO_WITH_PEEK_ACK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define BFPA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BFPA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFPA_ASSERT(lbl, prop, msg)
`define BFPA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/bfpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared constants, types and helpers of the burst FIFO with peek and ack.
// ----------------------------------------------------------------------------
package bfpa_pkg;

	localparam int STORE_DEPTH = 64;
	localparam int ITEM_BITS   = 32;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int OP_W        = 3;
	localparam int STAT_W      = 2;

	localparam int S_TDATA_W = ((ITEM_BITS + CNT_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((ITEM_BITS + 3 * CNT_W + 2 + 7) / 8) * 8;

	// job queue, power of two
	localparam int JQ_DEPTH = 4;
	localparam int JQ_AW    = $clog2(JQ_DEPTH);
	localparam int JQ_CW    = $clog2(JQ_DEPTH + 1);
	localparam int PEND_W   = $clog2(JQ_DEPTH + 3);

	localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
	localparam logic [OP_W-1:0] OP_READ  = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
	localparam logic [OP_W-1:0] OP_ACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_FLUSH = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
	localparam logic [STAT_W-1:0] ST_NONE   = 2'd2;

	typedef struct packed {
		logic              deliver;
		logic [ADDR_W-1:0] ptr;
		logic [CNT_W-1:0]  n;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  fill;
		logic [CNT_W-1:0]  space;
		logic              empty;
		logic              full;
	} job_t;

	typedef struct packed {
		logic              is_data;
		logic              last;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  delivered;
		logic [CNT_W-1:0]  fill;
		logic [CNT_W-1:0]  space;
		logic              empty;
		logic              full;
	} res_t;

	// p + n modulo depth, for p < depth and n <= depth
	function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] p,
			input logic [CNT_W-1:0] n, input logic [CNT_W-1:0] depth);
		logic [CNT_W:0] s;
		s = {{(CNT_W + 1 - ADDR_W){1'b0}}, p} + {1'b0, n};
		if (s >= {1'b0, depth}) begin
			s = s - {1'b0, depth};
		end
		return s[ADDR_W-1:0];
	endfunction

endpackage

// ===== hdl/burst_fifo_with_peek_ack_unit.sv =====
// ----------------------------------------------------------------------------
// burst_fifo_with_peek_ack_unit
// Circular FIFO with all-or-nothing burst writes, read, peek, ack and flush.
// ----------------------------------------------------------------------------
// Commands enter on the s_ stream: operation in s_tuser, element and count
// in s_tdata. Results leave on the m_ stream, m_tlast on the final beat of
// each command; status travels in m_tuser.
// While s_tready is high the front end takes one command per cycle and
// updates the pointers and occupancy at once; a four-entry job queue feeds
// the delivery back end. Write, ack, flush, unused codes and a read or peek
// that finds nothing give one result beat; read and peek otherwise give one
// beat per element, one per cycle while m_tready stays high, as the storage
// read port allows. A write waits while a read or peek is still reading
// storage, since its slot may be one that delivery has yet to read.
// Reset empties the queue and sets depth in use to 64; storage is not
// cleared. A write on cfg_we sets depth in use (saturated to 1..64) and
// empties the queue; write it only while the block is idle.
// When the receiver stalls, result beats hold, the job queue fills and then
// s_tready falls.
// ----------------------------------------------------------------------------
module burst_fifo_with_peek_ack_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bfpa_pkg::CNT_W-1:0]     cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// item_data, request_count
	input  logic [bfpa_pkg::S_TDATA_W-1:0] s_tdata,
	// operation
	input  logic [bfpa_pkg::OP_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// result_data, delivered_total, fill_level, space_left, empty_flag, full_flag
	output logic [bfpa_pkg::M_TDATA_W-1:0] m_tdata,
	// result_last
	output logic                           m_tlast,
	// status
	output logic [bfpa_pkg::STAT_W-1:0]    m_tuser
);
	import bfpa_pkg::*;

	job_t              push_job, head;
	res_t              res;
	logic              push, q_full, q_nonempty, pop, deliver_done;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [ITEM_BITS-1:0] mem_wdata, mem_rdata, res_data;
	logic [CNT_W-1:0]  depth;

	bfpa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd_valid    (s_tvalid),
		.cmd_ready    (s_tready),
		.cmd_op       (s_tuser),
		.cmd_data     (s_tdata[ITEM_BITS-1:0]),
		.cmd_count    (s_tdata[ITEM_BITS+CNT_W-1:ITEM_BITS]),
		.push         (push),
		.job          (push_job),
		.q_full       (q_full),
		.deliver_done (deliver_done),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.depth        (depth)
	);

	bfpa_job_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.nonempty (q_nonempty),
		.head     (head)
	);

	bfpa_ram #(
		.WIDTH (ITEM_BITS),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	bfpa_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.depth        (depth),
		.q_nonempty   (q_nonempty),
		.head         (head),
		.pop          (pop),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata),
		.deliver_done (deliver_done),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_res      (res),
		.out_data     (res_data)
	);

	assign m_tdata = M_TDATA_W'({res.full, res.empty, res.space, res.fill,
		res.delivered, res_data});
	assign m_tlast = res.last;
	assign m_tuser = res.status;

endmodule

// ===== hdl/bfpa_ram.sv =====
// ----------------------------------------------------------------------------
// bfpa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/bfpa_front.sv =====
// ----------------------------------------------------------------------------
// bfpa_front
// Command front end: pointers, occupancy, burst admission, storage writes.
// ----------------------------------------------------------------------------
`include "burst_fifo_with_peek_ack_unit_defines.svh"

module bfpa_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bfpa_pkg::CNT_W-1:0]     cfg_wdata,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  logic [bfpa_pkg::OP_W-1:0]      cmd_op,
	input  logic [bfpa_pkg::ITEM_BITS-1:0] cmd_data,
	input  logic [bfpa_pkg::CNT_W-1:0]     cmd_count,
	output logic                           push,
	output bfpa_pkg::job_t                 job,
	input  logic                           q_full,
	input  logic                           deliver_done,
	output logic                           mem_we,
	output logic [bfpa_pkg::ADDR_W-1:0]    mem_waddr,
	output logic [bfpa_pkg::ITEM_BITS-1:0] mem_wdata,
	output logic [bfpa_pkg::CNT_W-1:0]     depth
);
	import bfpa_pkg::*;

	logic [CNT_W-1:0]  depth_q, occ_q, brem_q;
	logic [ADDR_W-1:0] wp_q, rp_q;
	logic              bacc_q;
	logic [PEND_W-1:0] pend_q;

	logic [CNT_W-1:0]  occ_n, brem_n, space, len, take, cfg_sat;
	logic [ADDR_W-1:0] wp_n, rp_n;
	logic              bacc_n, store, flush, accept;

	assign cmd_ready = !q_full && !(cmd_op == OP_WRITE && pend_q != '0);
	assign accept    = cmd_valid && cmd_ready;
	assign push      = accept;
	assign depth     = depth_q;
	assign mem_waddr = wp_q;
	assign mem_wdata = cmd_data;
	assign mem_we    = accept && store;

	always_comb begin
		space  = depth_q - occ_q;
		len    = (cmd_count == '0) ? CNT_W'(1) : cmd_count;
		take   = (cmd_count < occ_q) ? cmd_count : occ_q;
		wp_n   = wp_q;
		rp_n   = rp_q;
		occ_n  = occ_q;
		brem_n = brem_q;
		bacc_n = bacc_q;
		store  = 1'b0;
		flush  = 1'b0;
		job.deliver = 1'b0;
		job.ptr     = rp_q;
		job.n       = '0;
		job.status  = ST_OK;
		unique case (cmd_op) inside
			OP_WRITE: begin
				if (brem_q == '0) begin
					bacc_n = (space >= len);
					brem_n = len - CNT_W'(1);
				end else begin
					brem_n = brem_q - CNT_W'(1);
				end
				if (bacc_n && occ_q < depth_q) begin
					store = 1'b1;
					wp_n  = wrap_add(wp_q, CNT_W'(1), depth_q);
					occ_n = occ_q + CNT_W'(1);
				end else begin
					job.status = ST_REJECT;
				end
			end
			OP_READ, OP_PEEK, OP_ACK: begin
				if (take == '0) begin
					job.status = ST_NONE;
				end else begin
					job.n       = take;
					job.deliver = (cmd_op != OP_ACK);
					if (cmd_op != OP_PEEK) begin
						rp_n  = wrap_add(rp_q, take, depth_q);
						occ_n = occ_q - take;
					end
				end
			end
			OP_FLUSH: begin
				flush = 1'b1;
				wp_n   = '0;
				rp_n   = '0;
				occ_n  = '0;
				brem_n = '0;
				bacc_n = 1'b0;
			end
			default: begin
			end
		endcase
		job.fill  = occ_n;
		job.space = depth_q - occ_n;
		job.empty = (occ_n == '0);
		job.full  = (occ_n == depth_q);
	end

	always_comb begin
		cfg_sat = cfg_wdata;
		if (cfg_wdata == '0) begin
			cfg_sat = CNT_W'(1);
		end else if (cfg_wdata > CNT_W'(STORE_DEPTH)) begin
			cfg_sat = CNT_W'(STORE_DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= CNT_W'(STORE_DEPTH);
			wp_q    <= '0;
			rp_q    <= '0;
			occ_q   <= '0;
			brem_q  <= '0;
			bacc_q  <= 1'b0;
			pend_q  <= '0;
		end else begin
			if (cfg_we) begin
				depth_q <= cfg_sat;
				wp_q    <= '0;
				rp_q    <= '0;
				occ_q   <= '0;
				brem_q  <= '0;
				bacc_q  <= 1'b0;
			end else if (accept) begin
				wp_q   <= wp_n;
				rp_q   <= rp_n;
				occ_q  <= occ_n;
				brem_q <= brem_n;
				bacc_q <= bacc_n;
			end
			pend_q <= pend_q + PEND_W'(accept && job.deliver) - PEND_W'(deliver_done);
		end
	end

	logic [CNT_W:0] tail_sum;
	logic [CNT_W:0] tail;
	assign tail_sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, rp_q} + {1'b0, occ_q};
	assign tail     = (tail_sum >= {1'b0, depth_q}) ? tail_sum - {1'b0, depth_q} : tail_sum;

	`BFPA_ASSERT(a_occ_le_depth, occ_q <= depth_q, "occupancy above depth in use")
	`BFPA_ASSERT(a_depth_range, depth_q != '0 && depth_q <= CNT_W'(STORE_DEPTH),
		"depth in use out of range")
	`BFPA_ASSERT(a_ptr_consistent, tail[ADDR_W-1:0] == wp_q && tail < {1'b0, depth_q},
		"write pointer disagrees with read pointer plus occupancy")
	`BFPA_ASSERT(a_no_write_under_read, mem_we |-> pend_q == '0,
		"storage written while a delivery is in flight")
	`BFPA_ASSERT(a_flush_clears, accept && flush |=> occ_q == '0 && brem_q == '0,
		"flush left entries or a burst behind")

endmodule

// ===== hdl/bfpa_job_queue.sv =====
// ----------------------------------------------------------------------------
// bfpa_job_queue
// Small register FIFO of jobs between front end and delivery back end.
// ----------------------------------------------------------------------------
module bfpa_job_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bfpa_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           nonempty,
	output bfpa_pkg::job_t head
);
	import bfpa_pkg::*;

	job_t             ent_q [JQ_DEPTH];
	logic [JQ_AW-1:0] wr_q, rd_q;
	logic [JQ_CW-1:0] cnt_q;

	assign full     = (cnt_q == JQ_CW'(JQ_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + JQ_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + JQ_AW'(1);
			end
			cnt_q <= cnt_q + JQ_CW'(push) - JQ_CW'(pop);
		end
	end

endmodule

// ===== hdl/bfpa_back.sv =====
// ----------------------------------------------------------------------------
// bfpa_back
// Delivery back end: expands jobs into result beats, storage read pipeline.
// ----------------------------------------------------------------------------
`include "burst_fifo_with_peek_ack_unit_defines.svh"

module bfpa_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [bfpa_pkg::CNT_W-1:0]     depth,
	input  logic                           q_nonempty,
	input  bfpa_pkg::job_t                 head,
	output logic                           pop,
	output logic                           mem_re,
	output logic [bfpa_pkg::ADDR_W-1:0]    mem_raddr,
	input  logic [bfpa_pkg::ITEM_BITS-1:0] mem_rdata,
	output logic                           deliver_done,
	output logic                           out_valid,
	input  logic                           out_ready,
	output bfpa_pkg::res_t                 out_res,
	output logic [bfpa_pkg::ITEM_BITS-1:0] out_data
);
	import bfpa_pkg::*;

	logic              active_q, s1_vld_s1, out_vld_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [CNT_W-1:0]  left_q;
	job_t              cur_q;
	res_t              res_s1, res_q;
	logic [ITEM_BITS-1:0] data_q;
	logic              advance;

	assign advance      = !out_vld_q || out_ready;
	assign pop          = advance && !active_q && q_nonempty;
	assign mem_re       = advance;
	assign mem_raddr    = active_q ? ptr_q : head.ptr;
	assign deliver_done = advance && s1_vld_s1 && res_s1.is_data && res_s1.last;
	assign out_valid    = out_vld_q;
	assign out_res      = res_q;
	assign out_data     = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			s1_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
			ptr_q     <= '0;
			left_q    <= '0;
		end else if (advance) begin
			out_vld_q <= s1_vld_s1;
			if (active_q) begin
				s1_vld_s1 <= 1'b1;
				ptr_q     <= wrap_add(ptr_q, CNT_W'(1), depth);
				left_q    <= left_q - CNT_W'(1);
				active_q  <= (left_q != CNT_W'(1));
			end else if (q_nonempty) begin
				s1_vld_s1 <= 1'b1;
				if (head.deliver && head.n != CNT_W'(1)) begin
					active_q <= 1'b1;
					ptr_q    <= wrap_add(head.ptr, CNT_W'(1), depth);
					left_q   <= head.n - CNT_W'(1);
				end
			end else begin
				s1_vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q  <= res_s1;
			data_q <= res_s1.is_data ? mem_rdata : '0;
			if (active_q) begin
				res_s1.is_data   <= 1'b1;
				res_s1.last      <= (left_q == CNT_W'(1));
				res_s1.status    <= cur_q.status;
				res_s1.delivered <= cur_q.n;
				res_s1.fill      <= cur_q.fill;
				res_s1.space     <= cur_q.space;
				res_s1.empty     <= cur_q.empty;
				res_s1.full      <= cur_q.full;
			end else begin
				cur_q            <= head;
				res_s1.is_data   <= head.deliver;
				res_s1.last      <= !head.deliver || head.n == CNT_W'(1);
				res_s1.status    <= head.status;
				res_s1.delivered <= head.n;
				res_s1.fill      <= head.fill;
				res_s1.space     <= head.space;
				res_s1.empty     <= head.empty;
				res_s1.full      <= head.full;
			end
		end
	end

	`BFPA_ASSERT(a_active_has_left, active_q |-> left_q != '0,
		"delivery active with no elements left")
	`BFPA_ASSERT(a_mid_burst_active, s1_vld_s1 && res_s1.is_data && !res_s1.last |-> active_q,
		"non-final element issued without an active delivery")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the burst FIFO with peek and ack. Commands stream
// in on the s_ side under random idle gaps, a scoreboard models the queue
// and checks every m_ beat field by field. Phases at several depth settings,
// saturated register values included; the last phase runs without stalls.
// ----------------------------------------------------------------------------
module tb;
	import bfpa_pkg::*;

	localparam int WATCHDOG_CYCLES = 1000;
	localparam int DLV_LO          = ITEM_BITS;
	localparam int FILL_LO         = DLV_LO + CNT_W;
	localparam int SPACE_LO        = FILL_LO + CNT_W;
	localparam int EMPTY_BIT       = SPACE_LO + CNT_W;
	localparam int FULL_BIT        = EMPTY_BIT + 1;

	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [ITEM_BITS-1:0] data;
		logic                 last;
		logic [STAT_W-1:0]    status;
		logic [CNT_W-1:0]     delivered;
		logic [CNT_W-1:0]     fill;
		logic [CNT_W-1:0]     space;
		logic                 empty;
		logic                 full;
	} beat_t;

	class fifo_scoreboard;
		logic [ITEM_BITS-1:0] store [STORE_DEPTH];
		int unsigned wr_ptr, rd_ptr, fill, burst_left, depth;
		bit burst_ok;
		beat_t expected_beats[$];
		int unsigned errors;
		int unsigned beats_checked;

		function new();
			depth = STORE_DEPTH;
			errors = 0;
			beats_checked = 0;
			drop_all();
		endfunction

		function void drop_all();
			wr_ptr = 0;
			rd_ptr = 0;
			fill = 0;
			burst_left = 0;
			burst_ok = 0;
		endfunction

		function int unsigned wrap(int unsigned p, int unsigned n);
			int unsigned q;
			q = p + n;
			while (q >= depth) q -= depth;
			return q;
		endfunction

		function void set_depth(logic [CNT_W-1:0] v);
			if (v < 1) depth = 1;
			else if (v > STORE_DEPTH) depth = STORE_DEPTH;
			else depth = v;
			drop_all();
		endfunction

		function void add_beat(logic [ITEM_BITS-1:0] data, bit last, logic [STAT_W-1:0] status,
				int unsigned delivered);
			beat_t b;
			int unsigned space;
			space       = depth - fill;
			b.data      = data;
			b.last      = last;
			b.status    = status;
			b.delivered = delivered[CNT_W-1:0];
			b.fill      = fill[CNT_W-1:0];
			b.space     = space[CNT_W-1:0];
			b.empty     = (fill == 0);
			b.full      = (fill == depth);
			expected_beats.push_back(b);
		endfunction

		function void note_command(logic [OP_W-1:0] op, logic [ITEM_BITS-1:0] data,
				logic [CNT_W-1:0] req);
			int unsigned len, n, p;
			case (op)
			OP_WRITE: begin
				if (burst_left == 0) begin
					len = (req == 0) ? 1 : req;
					burst_ok = (depth - fill) >= len;
					burst_left = len - 1;
				end else begin
					burst_left--;
				end
				if (burst_ok && fill < depth) begin
					store[wr_ptr] = data;
					wr_ptr = wrap(wr_ptr, 1);
					fill++;
					add_beat('0, 1, ST_OK, 0);
				end else begin
					add_beat('0, 1, ST_REJECT, 0);
				end
			end
			OP_READ, OP_PEEK, OP_ACK: begin
				n = (req < fill) ? req : fill;
				p = rd_ptr;
				if (n == 0) begin
					add_beat('0, 1, ST_NONE, 0);
				end else begin
					if (op != OP_PEEK) begin
						rd_ptr = wrap(rd_ptr, n);
						fill -= n;
					end
					if (op == OP_ACK) begin
						add_beat('0, 1, ST_OK, n);
					end else begin
						for (int k = 0; k < n; k++) begin
							add_beat(store[p], (k + 1 == n), ST_OK, n);
							p = wrap(p, 1);
						end
					end
				end
			end
			OP_FLUSH: begin
				drop_all();
				add_beat('0, 1, ST_OK, 0);
			end
			default: begin
				add_beat('0, 1, ST_OK, 0);
			end
			endcase
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] seen);
			if (seen !== want) begin
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, seen);
				errors++;
			end
		endfunction

		function void check_beat(beat_t got);
			beat_t want;
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected beat, expected none actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_beats.pop_front();
			beats_checked++;
			check_field("result_data", 32'(want.data), 32'(got.data));
			check_field("result_last", 32'(want.last), 32'(got.last));
			check_field("status", 32'(want.status), 32'(got.status));
			check_field("delivered_total", 32'(want.delivered), 32'(got.delivered));
			check_field("fill_level", 32'(want.fill), 32'(got.fill));
			check_field("space_left", 32'(want.space), 32'(got.space));
			check_field("empty_flag", 32'(want.empty), 32'(got.empty));
			check_field("full_flag", 32'(want.full), 32'(got.full));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CNT_W-1:0]     cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [OP_W-1:0]      s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;
	logic [STAT_W-1:0]    m_tuser;

	fifo_scoreboard sb;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned commands_sent;
	int unsigned depth_writes;
	int unsigned quiet_cycles;

	burst_fifo_with_peek_ack_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// one command beat, after an optional random idle gap
	task automatic issue(input logic [OP_W-1:0] op, input logic [ITEM_BITS-1:0] data,
			input int unsigned req);
		if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= S_TDATA_W'({$urandom, $urandom});
			s_tuser  <= OP_W'($urandom);
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= S_TDATA_W'({req[CNT_W-1:0], data});
		do @(posedge clk); while (!s_tready);
		sb.note_command(op, data, req[CNT_W-1:0]);
		commands_sent++;
	endtask

	task automatic program_depth(input int unsigned v);
		s_tvalid <= 1'b0;
		while (sb.expected_beats.size() != 0) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v[CNT_W-1:0];
		@(posedge clk);
		sb.set_depth(v[CNT_W-1:0]);
		depth_writes++;
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int unsigned n_items);
		int unsigned issued, space, len, pick, cap;
		logic [OP_W-1:0] op;
		issued = 0;
		while (issued < n_items) begin
			pick = $urandom_range(0, 99);
			op = OP_W'(OP_READ + $urandom_range(0, 2));
			cap = (sb.fill < STORE_DEPTH) ? sb.fill + 1 : STORE_DEPTH;
			if (pick < 50) begin
				space = sb.depth - sb.fill;
				case ($urandom_range(0, 9))
				0: len = (space == 0) ? 1 : space;
				1: len = (space + 1 > STORE_DEPTH) ? STORE_DEPTH : space + 1;
				2: len = 0;
				default: len = $urandom_range(1, (sb.depth < 8) ? sb.depth : 8);
				endcase
				for (int k = 0; k < ((len == 0) ? 1 : len); k++) begin
					if (k != 0 && issued >= n_items) break;
					if (k != 0 && $urandom_range(0, 9) == 0) begin
						issue(op, $urandom, $urandom_range(0, cap));
						issued++;
					end
					if (k != 0 && $urandom_range(0, 29) == 0) begin
						issue(OP_FLUSH, $urandom, $urandom_range(0, STORE_DEPTH));
						issued++;
						break;
					end
					issue(OP_WRITE, $urandom, (k == 0) ? len : $urandom_range(0, STORE_DEPTH));
					issued++;
				end
			end else if (pick < 85) begin
				case ($urandom_range(0, 7))
				0: issue(op, $urandom, STORE_DEPTH);
				1: issue(op, $urandom, $urandom_range(0, STORE_DEPTH));
				default: issue(op, $urandom, $urandom_range(0, sb.fill));
				endcase
				issued++;
			end else if (pick < 92) begin
				issue(OP_FLUSH, $urandom, $urandom_range(0, STORE_DEPTH));
				issued++;
			end else begin
				// lone write, may leave a burst open
				issue(OP_WRITE, $urandom, $urandom_range(0, STORE_DEPTH));
				issued++;
			end
		end
	endtask

	// result side: check accepted beats, stall in random bursts
	initial begin
		int unsigned stall_left;
		beat_t got;
		stall_left = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.data      = m_tdata[ITEM_BITS-1:0];
				got.delivered = m_tdata[DLV_LO +: CNT_W];
				got.fill      = m_tdata[FILL_LO +: CNT_W];
				got.space     = m_tdata[SPACE_LO +: CNT_W];
				got.empty     = m_tdata[EMPTY_BIT];
				got.full      = m_tdata[FULL_BIT];
				got.last      = m_tlast;
				got.status    = m_tuser;
				sb.check_beat(got);
			end
			if (stall_left != 0) stall_left--;
			else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
				stall_left = $urandom_range(1, 8);
			m_tready <= (stall_left == 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_CYCLES) begin
			$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_CYCLES);
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		commands_sent = 0;
		depth_writes  = 0;
		idle_pct      = 20;
		stall_pct     = 20;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: nothing to deliver; then a three-write burst, peek, read, ack and the spare codes
		issue(OP_READ, 32'h0, STORE_DEPTH);
		issue(OP_PEEK, 32'hFFFF_FFFF, 1);
		issue(OP_ACK, 32'h0, 0);
		issue(OP_WRITE, 32'h0000_0000, 3);
		issue(OP_WRITE, 32'hFFFF_FFFF, STORE_DEPTH);
		issue(OP_WRITE, 32'hA5A5_A5A5, 0);
		issue(OP_PEEK, 32'h0, 2);
		issue(OP_READ, 32'h0, STORE_DEPTH);
		issue(OP_WRITE, 32'h5A5A_5A5A, 0);
		issue(OP_ACK, 32'h0, 5);
		for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++)
			issue(OP_W'(c), 32'hFFFF_FFFF, STORE_DEPTH);
		// other commands inside a burst, then a flush that ends it
		issue(OP_WRITE, 32'h1234_5678, 4);
		issue(OP_READ, 32'h0, 1);
		issue(OP_WRITE, 32'h8765_4321, 0);
		issue(OP_FLUSH, 32'h0, 0);
		issue(OP_WRITE, 32'hDEAD_BEEF, 1);
		issue(OP_PEEK, 32'h0, 1);

		program_depth(2);
		issue(OP_WRITE, 32'h1111_1111, 3);
		issue(OP_WRITE, 32'h2222_2222, 0);
		issue(OP_WRITE, 32'h3333_3333, 0);
		issue(OP_WRITE, 32'h4444_4444, 2);
		issue(OP_WRITE, 32'h5555_5555, 0);
		issue(OP_WRITE, 32'h6666_6666, 1);
		issue(OP_READ, 32'h0, 2);

		idle_pct  = 30;
		stall_pct = 30;
		program_depth(0);
		random_phase(15);

		idle_pct  = 0;
		stall_pct = 0;
		program_depth(127);
		random_phase(25);

		idle_pct  = 40;
		stall_pct = 15;
		program_depth($urandom_range(3, STORE_DEPTH - 1));
		random_phase(15);

		idle_pct  = 15;
		stall_pct = 40;
		program_depth(1);
		random_phase(10);

		idle_pct  = 0;
		stall_pct = 0;
		program_depth(STORE_DEPTH);
		random_phase(10);

		s_tvalid <= 1'b0;
		while (sb.expected_beats.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d commands and %0d result beats over %0d depth settings,",
			commands_sent, sb.beats_checked, depth_writes);
		$display("including depths 1, 2, 64, saturated 0 and 127, with random stalls.");
		if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
